// ===== rtl/core/i2c_eeprom_access_master_macros.svh =====
// ----------------------------------------------------------------------------
// I2C EEPROM access master: assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_ACCESS_MASTER_MACROS_SVH
`define I2C_EEPROM_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define I2CEAM_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CEAM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/i2ceam_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM access master package
// Phase type, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2ceam_pkg;

    // Bus phases of one transaction.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SEND  = 3'd2,
        PH_ACK   = 3'd3,
        PH_READ  = 3'd4,
        PH_NACK  = 3'd5,
        PH_STOP  = 3'd6
    } t_phase;

    // Request codes carried by each input beat.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEV_ADDR     = 2'd0;
    localparam logic [1:0] REG_QUARTER_BIT  = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [6:0]  DEV_ADDR_RESET    = 7'd15;
    localparam logic [15:0] QUARTER_BIT_RESET = 16'd8;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // Last quarter of a bit slot and bits per byte.
    localparam logic [1:0] LAST_QUARTER  = 2'd3;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_eeprom_access_master.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM access master
// Tick-driven I2C master for a memory with a 16-bit address: one-byte random
// read and one-word write, with acknowledge timeout and abort.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   --------  --------------------------  ------------------------------------
//   input     i_in_valid / o_in_ready     i_op, i_mem_address, i_write_word,
//                                         i_sda_in
//   result    o_out_valid / i_out_ready   o_scl, o_sda_out, o_sda_drive,
//                                         o_busy_res, o_done_res,
//                                         o_read_byte, o_ack_error
//   config    i_cfg_wr_en (no wait)       i_cfg_index, i_cfg_wdata
//
// Every input beat is one bus tick and yields exactly one result beat.
// A beat is taken every clock cycle unless the input side stalls; its result is
// registered in the output register, so the throughput is one beat/cycle.
// The input side stalls only while the output register is full and not taken.
// Reset is synchronous and active low; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_access_master_macros.svh"

module i2c_eeprom_access_master (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    // Input beats (one bus tick each)
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_mem_address,
    input  wire logic [15:0] i_write_word,
    input  wire logic        i_sda_in,
    // Result beats
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_scl,
    output logic             o_sda_out,
    output logic             o_sda_drive,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [7:0]       o_read_byte,
    output logic             o_ack_error
);

    // Configuration registers.
    logic [6:0]  r_dev_addr;
    logic [15:0] r_quarter_bit;
    logic [7:0]  r_ack_timeout;

    // Transaction state.
    i2ceam_pkg::t_phase r_phase, n_phase, e_phase;
    logic [1:0]  r_quarter, n_quarter, e_quarter;
    logic [15:0] r_tick, n_tick, e_tick;
    logic [3:0]  r_bit_count, n_bit_count, e_bit_count;
    logic [2:0]  r_byte_step, n_byte_step, e_byte_step;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_received, n_received;
    logic [15:0] r_held_addr, n_held_addr, e_held_addr;
    logic [15:0] r_held_word, n_held_word, e_held_word;
    logic        r_is_read, n_is_read, e_is_read;
    logic [7:0]  r_ack_wait, n_ack_wait;
    logic        r_error, n_error, e_error;

    // Output register.
    logic        r_out_valid;
    logic        r_scl, r_sda_out, r_sda_drive, r_busy, r_done, r_ack_error;
    logic [7:0]  r_read_byte;

    // Per-beat combinational results.
    logic        accept;
    logic        start_req;
    logic        c_scl, c_sda_out, c_sda_drive, c_done;
    logic [15:0] quarter_len;
    logic [16:0] tick_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  sampled;

    // Byte sent for a given step of the transaction.
    function automatic logic [7:0] byte_for_step(
        input logic [2:0]  step,
        input logic        is_read,
        input logic [6:0]  dev,
        input logic [15:0] addr,
        input logic [15:0] word
    );
        logic [7:0] b;
        case (step)
            3'd0:    b = {dev, 1'b0};
            3'd1:    b = addr[15:8];
            3'd2:    b = addr[7:0];
            3'd3:    b = is_read ? {dev, 1'b1} : word[7:0];
            default: b = word[15:8];
        endcase
        return b;
    endfunction

    // The output register frees up either when empty or when taken this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // A zero quarter length behaves like one tick.
    assign quarter_len = (r_quarter_bit == 16'd0) ? 16'd1 : r_quarter_bit;

    // A read or write request only counts in idle; any other code is a plain tick.
    assign start_req = (r_phase == i2ceam_pkg::PH_IDLE) &&
                       ((i_op == i2ceam_pkg::OP_READ) || (i_op == i2ceam_pkg::OP_WRITE));

    // Effective state for this tick: a request loads the transaction and enters
    // the start slot before the line levels are worked out.
    always_comb begin
        e_phase     = r_phase;
        e_quarter   = r_quarter;
        e_tick      = r_tick;
        e_bit_count = r_bit_count;
        e_byte_step = r_byte_step;
        e_held_addr = r_held_addr;
        e_held_word = r_held_word;
        e_is_read   = r_is_read;
        e_error     = r_error;
        if (start_req) begin
            e_held_addr = i_mem_address;
            e_held_word = i_write_word;
            e_is_read   = (i_op == i2ceam_pkg::OP_READ);
            e_error     = 1'b0;
            e_byte_step = 3'd0;
            e_bit_count = 4'd0;
            e_phase     = i2ceam_pkg::PH_START;
            e_quarter   = 2'd0;
            e_tick      = 16'd0;
        end
    end

    // Line levels for this tick. SCL is high in the two middle quarters, in stop quarters 1-3 and in idle.
    always_comb begin
        logic high;
        high        = (e_quarter == 2'd1) || (e_quarter == 2'd2);
        c_scl       = 1'b1;
        c_sda_out   = 1'b1;
        c_sda_drive = 1'b1;
        case (e_phase)
            i2ceam_pkg::PH_START: begin
                c_scl     = high;
                c_sda_out = (e_quarter < 2'd2);
            end
            i2ceam_pkg::PH_SEND: begin
                c_scl     = high;
                c_sda_out = r_shift[7];
            end
            i2ceam_pkg::PH_ACK, i2ceam_pkg::PH_READ: begin
                c_scl       = high;
                c_sda_drive = 1'b0;
            end
            i2ceam_pkg::PH_NACK: begin
                c_scl = high;
            end
            i2ceam_pkg::PH_STOP: begin
                c_scl     = (e_quarter != 2'd0);
                c_sda_out = (e_quarter >= 2'd2);
            end
            default: begin
            end
        endcase
    end

    // Next state: quarter timing, acknowledge wait, and the slot sequencer
    // that runs when the last quarter of a slot ends.
    always_comb begin
        n_phase     = e_phase;
        n_quarter   = e_quarter;
        n_tick      = e_tick;
        n_bit_count = e_bit_count;
        n_byte_step = e_byte_step;
        n_shift     = r_shift;
        n_received  = r_received;
        n_held_addr = e_held_addr;
        n_held_word = e_held_word;
        n_is_read   = e_is_read;
        n_ack_wait  = r_ack_wait;
        n_error     = e_error;
        c_done      = 1'b0;
        sampled     = r_shift;
        tick_inc    = {1'b0, e_tick} + 17'd1;
        bit_inc     = e_bit_count + 4'd1;

        if ((e_phase == i2ceam_pkg::PH_ACK) && (e_quarter == 2'd1)) begin
            // SCL stays high and SDA is sampled every tick until the device pulls it low or the wait times out.
            if (!i_sda_in) begin
                n_quarter = 2'd2;
                n_tick    = 16'd0;
            end else if (r_ack_wait >= r_ack_timeout) begin
                n_error   = 1'b1;
                n_phase   = i2ceam_pkg::PH_STOP;
                n_quarter = 2'd0;
                n_tick    = 16'd0;
            end else begin
                n_ack_wait = r_ack_wait + 8'd1;
            end
        end else if (e_phase != i2ceam_pkg::PH_IDLE) begin
            // Read data is taken on the first tick of the third quarter.
            if ((e_phase == i2ceam_pkg::PH_READ) && (e_quarter == 2'd2) &&
                (e_tick == 16'd0)) begin
                sampled = {r_shift[6:0], i_sda_in};
            end
            n_shift = sampled;
            n_tick  = tick_inc[15:0];
            if (tick_inc >= {1'b0, quarter_len}) begin
                n_tick = 16'd0;
                if (e_quarter != i2ceam_pkg::LAST_QUARTER) begin
                    n_quarter = e_quarter + 2'd1;
                end else begin
                    n_quarter = 2'd0;
                    case (e_phase)
                        i2ceam_pkg::PH_START: begin
                            n_shift     = byte_for_step(e_byte_step, e_is_read, r_dev_addr,
                                                        e_held_addr, e_held_word);
                            n_bit_count = 4'd0;
                            n_phase     = i2ceam_pkg::PH_SEND;
                        end
                        i2ceam_pkg::PH_SEND: begin
                            n_shift     = {sampled[6:0], 1'b0};
                            n_bit_count = bit_inc;
                            if (bit_inc >= i2ceam_pkg::BITS_PER_BYTE) begin
                                n_ack_wait = 8'd0;
                                n_phase    = i2ceam_pkg::PH_ACK;
                            end
                        end
                        i2ceam_pkg::PH_ACK: begin
                            if (e_is_read && (e_byte_step == 3'd2)) begin
                                // Address sent: repeated start, then the read address.
                                n_byte_step = 3'd3;
                                n_phase     = i2ceam_pkg::PH_START;
                            end else if (e_is_read && (e_byte_step >= 3'd3)) begin
                                n_shift     = 8'd0;
                                n_bit_count = 4'd0;
                                n_phase     = i2ceam_pkg::PH_READ;
                            end else if (!e_is_read && (e_byte_step >= 3'd4)) begin
                                n_phase = i2ceam_pkg::PH_STOP;
                            end else begin
                                n_byte_step = e_byte_step + 3'd1;
                                n_shift     = byte_for_step(e_byte_step + 3'd1, e_is_read,
                                                            r_dev_addr, e_held_addr,
                                                            e_held_word);
                                n_bit_count = 4'd0;
                                n_phase     = i2ceam_pkg::PH_SEND;
                            end
                        end
                        i2ceam_pkg::PH_READ: begin
                            n_bit_count = bit_inc;
                            if (bit_inc >= i2ceam_pkg::BITS_PER_BYTE) begin
                                n_received = sampled;
                                n_phase    = i2ceam_pkg::PH_NACK;
                            end
                        end
                        i2ceam_pkg::PH_NACK: begin
                            n_phase = i2ceam_pkg::PH_STOP;
                        end
                        default: begin
                            // End of the stop slot closes the transaction.
                            n_phase = i2ceam_pkg::PH_IDLE;
                            c_done  = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // Configuration registers; index three is unused and ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= i2ceam_pkg::DEV_ADDR_RESET;
            r_quarter_bit <= i2ceam_pkg::QUARTER_BIT_RESET;
            r_ack_timeout <= i2ceam_pkg::ACK_TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                i2ceam_pkg::REG_DEV_ADDR:    r_dev_addr    <= i_cfg_wdata[6:0];
                i2ceam_pkg::REG_QUARTER_BIT: r_quarter_bit <= i_cfg_wdata;
                i2ceam_pkg::REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Transaction state advances once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2ceam_pkg::PH_IDLE;
            r_quarter   <= 2'd0;
            r_tick      <= 16'd0;
            r_bit_count <= 4'd0;
            r_byte_step <= 3'd0;
            r_shift     <= 8'd0;
            r_received  <= 8'd0;
            r_held_addr <= 16'd0;
            r_held_word <= 16'd0;
            r_is_read   <= 1'b0;
            r_ack_wait  <= 8'd0;
            r_error     <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_quarter   <= n_quarter;
            r_tick      <= n_tick;
            r_bit_count <= n_bit_count;
            r_byte_step <= n_byte_step;
            r_shift     <= n_shift;
            r_received  <= n_received;
            r_held_addr <= n_held_addr;
            r_held_word <= n_held_word;
            r_is_read   <= n_is_read;
            r_ack_wait  <= n_ack_wait;
            r_error     <= n_error;
        end
    end

    // Result register: valid bit under reset, payload loads on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scl       <= c_scl;
            r_sda_out   <= c_sda_out;
            r_sda_drive <= c_sda_drive;
            r_busy      <= (e_phase != i2ceam_pkg::PH_IDLE);
            r_done      <= c_done;
            r_read_byte <= n_received;
            r_ack_error <= n_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_scl;
    assign o_sda_out   = r_sda_out;
    assign o_sda_drive = r_sda_drive;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_read_byte = r_read_byte;
    assign o_ack_error = r_ack_error;

    // A finishing beat always belongs to a transaction.
    `I2CEAM_ASSERT_IMPLIES(a_done_in_busy, i_clk, i_rst_n, o_out_valid && o_done_res, o_busy_res, "done beat outside a transaction")
    // A released SDA line always reports a high output level.
    `I2CEAM_ASSERT_IMPLIES(a_released_high, i_clk, i_rst_n, o_out_valid && !o_sda_drive, o_sda_out, "sda_out low while released")
    // Idle keeps the slot timing cleared.
    `I2CEAM_ASSERT_IMPLIES(a_idle_timing, i_clk, i_rst_n, r_phase == i2ceam_pkg::PH_IDLE, (r_quarter == 2'd0) && (r_tick == 16'd0), "idle with running slot timer")
    // An accepted beat always shows up in the result register next cycle.
    `I2CEAM_ASSERT_NEXT(a_beat_lands, i_clk, i_rst_n, accept, o_out_valid && (r_bit_count <= i2ceam_pkg::BITS_PER_BYTE), "accepted beat lost or bit count overrun")

endmodule

`default_nettype wire

// ===== bench/i2ceam_level_checker.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM access master: bus level checker
// Follows every input beat with its own model of the tick-driven bus master,
// queues the bus levels that each beat must produce and compares them, field
// by field, with the result beats that the block hands out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2ceam_level_checker
    import i2ceam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_mem_address,
    input  logic [15:0] i_write_word,
    input  logic        i_sda_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_scl,
    input  logic        i_sda_out,
    input  logic        i_sda_drive,
    input  logic        i_busy_res,
    input  logic        i_done_res,
    input  logic [7:0]  i_read_byte,
    input  logic        i_ack_error,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_model_idle,
    output int          o_results,
    output int          o_txns,
    output int          o_aborts
);

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       ack_error;
    } bus_levels_t;

    // Configuration copy.
    logic [6:0]  dev_addr;
    logic [15:0] quarter_len;
    logic [7:0]  ack_limit;

    // Bus master state.
    t_phase      bus_phase;
    logic [1:0]  quarter;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_cnt;
    logic [2:0]  byte_idx;
    logic [7:0]  shifter;
    logic [7:0]  rx_byte;
    logic [15:0] addr_hold;
    logic [15:0] word_hold;
    logic        rd_txn;
    logic [7:0]  ack_waits;
    logic        err_flag;

    bus_levels_t pending_levels[$];
    int          mismatches;
    int          results;
    int          txns;
    int          aborts;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH at %0t ns: %s expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endtask

    task automatic reset_model();
        dev_addr    = DEV_ADDR_RESET;
        quarter_len = QUARTER_BIT_RESET;
        ack_limit   = ACK_TIMEOUT_RESET;
        bus_phase   = PH_IDLE;
        quarter     = '0;
        tick_cnt    = '0;
        bit_cnt     = '0;
        byte_idx    = '0;
        shifter     = '0;
        rx_byte     = '0;
        addr_hold   = '0;
        word_hold   = '0;
        rd_txn      = 1'b0;
        ack_waits   = '0;
        err_flag    = 1'b0;
    endtask

    task automatic enter_phase(input t_phase ph);
        bus_phase = ph;
        quarter   = '0;
        tick_cnt  = '0;
    endtask

    // Byte that goes out at the current position of the transaction.
    function automatic logic [7:0] next_byte();
        case (byte_idx)
            3'd0:    return {dev_addr, 1'b0};
            3'd1:    return addr_hold[15:8];
            3'd2:    return addr_hold[7:0];
            3'd3:    return rd_txn ? {dev_addr, 1'b1} : word_hold[7:0];
            default: return word_hold[15:8];
        endcase
    endfunction

    task automatic load_byte();
        shifter = next_byte();
        bit_cnt = '0;
        enter_phase(PH_SEND);
    endtask

    // Runs when the last quarter of a bit slot ends.
    task automatic close_slot(output logic finished);
        finished = 1'b0;
        case (bus_phase)
            PH_START: load_byte();
            PH_SEND: begin
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= BITS_PER_BYTE) begin
                    ack_waits = '0;
                    enter_phase(PH_ACK);
                end else begin
                    enter_phase(PH_SEND);
                end
            end
            PH_ACK: begin
                if (rd_txn) begin
                    // After the low address byte comes the repeated start.
                    if (byte_idx == 3'd2) begin
                        byte_idx = 3'd3;
                        enter_phase(PH_START);
                    end else if (byte_idx >= 3'd3) begin
                        shifter = '0;
                        bit_cnt = '0;
                        enter_phase(PH_READ);
                    end else begin
                        byte_idx = byte_idx + 3'd1;
                        load_byte();
                    end
                end else if (byte_idx >= 3'd4) begin
                    enter_phase(PH_STOP);
                end else begin
                    byte_idx = byte_idx + 3'd1;
                    load_byte();
                end
            end
            PH_READ: begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= BITS_PER_BYTE) begin
                    rx_byte = shifter;
                    enter_phase(PH_NACK);
                end else begin
                    enter_phase(PH_READ);
                end
            end
            PH_NACK: enter_phase(PH_STOP);
            default: begin
                enter_phase(PH_IDLE);
                finished = 1'b1;
            end
        endcase
    endtask

    // One bus tick: the levels of this tick, then the state for the next one.
    task automatic step_bus_model(input logic [1:0] op, input logic [15:0] addr,
                                  input logic [15:0] word, input logic sda,
                                  output bus_levels_t lv);
        logic [15:0] qlen;
        logic        scl_high;
        logic        finished;
        qlen     = (quarter_len == '0) ? 16'd1 : quarter_len;
        lv       = '0;
        lv.scl       = 1'b1;
        lv.sda_out   = 1'b1;
        lv.sda_drive = 1'b1;
        scl_high = (quarter == 2'd1) || (quarter == 2'd2);

        if (bus_phase == PH_IDLE && (op == OP_READ || op == OP_WRITE)) begin
            addr_hold = addr;
            word_hold = word;
            rd_txn    = (op == OP_READ);
            err_flag  = 1'b0;
            byte_idx  = '0;
            bit_cnt   = '0;
            enter_phase(PH_START);
            scl_high  = 1'b0;
        end
        lv.busy = (bus_phase != PH_IDLE);

        case (bus_phase)
            PH_START: begin
                lv.scl     = scl_high;
                lv.sda_out = (quarter < 2'd2);
            end
            PH_SEND: begin
                lv.scl     = scl_high;
                lv.sda_out = shifter[7];
            end
            PH_ACK, PH_READ: begin
                lv.scl       = scl_high;
                lv.sda_drive = 1'b0;
            end
            PH_NACK: lv.scl = scl_high;
            PH_STOP: begin
                lv.scl     = (quarter != 2'd0);
                lv.sda_out = (quarter >= 2'd2);
            end
            default: ;
        endcase

        if (bus_phase == PH_ACK && quarter == 2'd1) begin
            if (!sda) begin
                quarter  = 2'd2;
                tick_cnt = '0;
            end else if (ack_waits >= ack_limit) begin
                err_flag = 1'b1;
                enter_phase(PH_STOP);
            end else begin
                ack_waits = ack_waits + 8'd1;
            end
        end else if (bus_phase != PH_IDLE) begin
            if (bus_phase == PH_READ && quarter == 2'd2 && tick_cnt == '0) begin
                shifter = {shifter[6:0], sda};
            end
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= qlen) begin
                tick_cnt = '0;
                if (quarter < LAST_QUARTER) begin
                    quarter = quarter + 2'd1;
                end else begin
                    close_slot(finished);
                    lv.done = finished;
                end
            end
        end
        lv.read_byte = rx_byte;
        lv.ack_error = err_flag;
    endtask

    initial begin
        mismatches = 0;
        results    = 0;
        txns       = 0;
        aborts     = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        bus_levels_t got;
        bus_levels_t want;
        bus_levels_t next_lv;
        if (!i_rst_n) begin
            reset_model();
            pending_levels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{scl: i_scl, sda_out: i_sda_out, sda_drive: i_sda_drive,
                        busy: i_busy_res, done: i_done_res,
                        read_byte: i_read_byte, ack_error: i_ack_error};
                if (pending_levels.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 8'h0, 8'h0);
                end else begin
                    want = pending_levels.pop_front();
                    results++;
                    if (want.done) begin
                        txns++;
                        if (want.ack_error) aborts++;
                    end
                    if (got.scl !== want.scl)
                        report_mismatch("scl", want.scl, got.scl);
                    if (got.sda_out !== want.sda_out)
                        report_mismatch("sda_out", want.sda_out, got.sda_out);
                    if (got.sda_drive !== want.sda_drive)
                        report_mismatch("sda_drive", want.sda_drive, got.sda_drive);
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", want.busy, got.busy);
                    if (got.done !== want.done)
                        report_mismatch("done_res", want.done, got.done);
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", want.read_byte, got.read_byte);
                    if (got.ack_error !== want.ack_error)
                        report_mismatch("ack_error", want.ack_error, got.ack_error);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_DEV_ADDR:    dev_addr    = i_cfg_wdata[6:0];
                    REG_QUARTER_BIT: quarter_len = i_cfg_wdata;
                    REG_ACK_TIMEOUT: ack_limit   = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_bus_model(i_op, i_mem_address, i_write_word, i_sda_in, next_lv);
                pending_levels.push_back(next_lv);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_levels.size();
        o_model_idle <= (bus_phase == PH_IDLE);
        o_results    <= results;
        o_txns       <= txns;
        o_aborts     <= aborts;
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM access master: testbench top
// Drives bus ticks, read and write requests and register settings into the
// block, with random gaps on the input side and random stalls on the result
// side, and leaves prediction and comparison to the level checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import i2ceam_pkg::*;

    // Op code 3 is not a request: the block must treat it as a plain tick.
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    // Index 3 has no register behind it, so a write there must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_op          = OP_TICK;
    logic [15:0] i_mem_address = '0;
    logic [15:0] i_write_word  = '0;
    logic        i_sda_in      = 1'b1;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_scl;
    logic        o_sda_out;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        o_ack_error;

    int   fail_count;
    int   pending;
    logic model_idle;
    int   results;
    int   txns;
    int   aborts;

    // Percent chance of a gap before each input beat, and of a stall on the
    // result side in each cycle.
    int   in_gap_pct    = 17;
    int   out_stall_pct = 79;
    // Remaining ticks of a forced run of SDA high; long runs are what make
    // an acknowledge wait time out.
    int   sda_high_run  = 0;

    i2c_eeprom_access_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_mem_address (i_mem_address),
        .i_write_word  (i_write_word),
        .i_sda_in      (i_sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_scl         (o_scl),
        .o_sda_out     (o_sda_out),
        .o_sda_drive   (o_sda_drive),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_byte   (o_read_byte),
        .o_ack_error   (o_ack_error)
    );

    i2ceam_level_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_mem_address (i_mem_address),
        .i_write_word  (i_write_word),
        .i_sda_in      (i_sda_in),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_scl         (o_scl),
        .i_sda_out     (o_sda_out),
        .i_sda_drive   (o_sda_drive),
        .i_busy_res    (o_busy_res),
        .i_done_res    (o_done_res),
        .i_read_byte   (o_read_byte),
        .i_ack_error   (o_ack_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_model_idle  (model_idle),
        .o_results     (results),
        .o_txns        (txns),
        .o_aborts      (aborts)
    );

    always #5 i_clk = ~i_clk;

    // The result side decides afresh every cycle whether it takes a beat.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // Mostly a fair coin, now and then a run of highs long enough to outlast
    // a short acknowledge timeout.
    function automatic logic pick_sda();
        if (sda_high_run > 0) begin
            sda_high_run--;
            return 1'b1;
        end
        if ($urandom_range(0, 39) == 0) sda_high_run = $urandom_range(4, 24);
        return 1'($urandom_range(0, 1));
    endfunction

    // Presents one beat and returns just after the edge that accepts it.
    // Valid is only lowered for a gap, so a back-to-back beat keeps it high.
    task automatic send_beat(input logic [1:0] op, input logic [15:0] addr,
                             input logic [15:0] word, input logic sda);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_mem_address <= addr;
        i_write_word  <= word;
        i_sda_in      <= sda;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Requests are frequent enough that the master is nearly always busy;
    // the ones that arrive mid-transaction must be ignored.
    task automatic send_random_beat();
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < 55)      op = OP_TICK;
        else if (r < 75) op = OP_READ;
        else if (r < 95) op = OP_WRITE;
        else             op = OP_UNUSED;
        send_beat(op, 16'($urandom), 16'($urandom), pick_sda());
    endtask

    // Ticks the bus until the running transaction is over, then waits for
    // every result beat, so that registers can be changed safely. The idle
    // flag is looked at only once it reflects the last accepted beat.
    task automatic settle_bus();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (!model_idle) begin
            send_beat(OP_TICK, 16'($urandom), 16'($urandom), pick_sda());
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Leaves the write enable high so that writes can follow each other.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry random values; the block must drop them.
    task automatic set_config(input logic [6:0] dev, input logic [15:0] qlen,
                              input logic [7:0] timeout);
        logic [15:0] w;
        w = 16'($urandom);
        w[6:0] = dev;
        write_reg(REG_DEV_ADDR, w);
        write_reg(REG_QUARTER_BIT, qlen);
        w = 16'($urandom);
        w[7:0] = timeout;
        write_reg(REG_ACK_TIMEOUT, w);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at the reset settings: field extremes in idle, the
        // unused op code, then a word write to the top address with all ones,
        // and requests arriving while it runs. SDA then stays high, so the
        // first acknowledge wait runs out at the reset timeout and the write
        // ends with an abort.
        send_beat(OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(OP_TICK, 16'hFFFF, 16'h0000, 1'b1);
        send_beat(OP_WRITE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_beat(OP_READ, 16'h0000, 16'h0000, 1'b1);
        send_beat(OP_WRITE, 16'h0000, 16'h0000, 1'b0);
        send_beat(OP_UNUSED, 16'h8001, 16'h7FFE, 1'b1);
        for (i = 0; i < 13; i++) begin
            send_beat(OP_TICK, 16'h00FF, 16'hFF00, 1'(i));
        end
        for (i = 0; i < 575; i++) begin
            send_beat(OP_TICK, 16'hFFFF, 16'h0000, 1'b1);
        end
        settle_bus();

        // Fastest bit slots, device address zero, the longest ack timeout.
        // A read of address zero opens the phase so that a byte comes back.
        set_config(7'd0, 16'd1, 8'd255);
        send_beat(OP_READ, 16'h0000, 16'h0000, 1'b0);
        repeat (130) send_random_beat();
        settle_bus();

        // Now the sender is the slow side.
        in_gap_pct    = 79;
        out_stall_pct = 17;

        // Zero quarter length behaves as one; zero timeout aborts on the
        // first high acknowledge sample, which also aborts reads halfway.
        set_config(7'd127, 16'd0, 8'd0);
        repeat (90) send_random_beat();
        settle_bus();

        set_config(7'h55, 16'd2, 8'd3);
        repeat (90) send_random_beat();
        settle_bus();

        // No idling from here on.
        in_gap_pct    = 0;
        out_stall_pct = 0;

        // Longest quarter: only idle ticks, since one transaction would outlast
        // the time limit of the run. The write to the missing index goes first.
        write_reg(REG_UNUSED, 16'hFFFF);
        set_config(7'h2A, 16'hFFFF, 8'd1);
        repeat (40) begin
            send_beat($urandom_range(0, 1) ? OP_TICK : OP_UNUSED,
                      16'($urandom), 16'($urandom), pick_sda());
        end
        settle_bus();

        set_config(7'($urandom), 16'd1, 8'($urandom_range(2, 40)));
        for (i = 0; i < 130; i++) begin
            if (i == 65) begin
                // Hold the input back until every result is out.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            send_random_beat();
        end
        settle_bus();

        $display("Checked %0d result beats over %0d finished transactions, %0d aborted",
                 results, txns, aborts);
        $display("for a missing acknowledge, across six register settings.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timed out waiting for result beats");
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2ceam_pkg.sv
rtl/core/i2c_eeprom_access_master.sv
bench/i2ceam_level_checker.sv
bench/tb.sv
